// File: rtl/tef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tef_pkg
// Shared constants, types and helpers for the touch event finger tracker.
// ----------------------------------------------------------------------------
package tef_pkg;

    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [4:0] CMD_SYNC   = 5'd0;
    localparam logic [4:0] CMD_KEY    = 5'd1;
    localparam logic [4:0] CMD_ABS    = 5'd3;
    localparam logic [4:0] CMD_FINGER = 5'hf;

    localparam logic [9:0] KEY_TOUCH = 10'd330;
    localparam logic [9:0] AXIS_X    = 10'd0;
    localparam logic [9:0] AXIS_Y    = 10'd1;

    localparam logic [31:0] ID_SCALE       = 32'd1000;
    localparam logic [31:0] UNSET_PRESSURE = '1;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [4:0]  command;
        logic [9:0]  code;
        logic [31:0] value;
        logic [31:0] finger_id;
    } event_t;

    typedef struct packed {
        logic [2:0]  slot;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pressure;
    } sample_t;

    function automatic logic [2:0] slot_field(slot_idx_t s);
        logic [SLOT_W+2:0] wide;
        wide = {3'b000, s};
        return wide[2:0];
    endfunction

endpackage

// File: rtl/tef_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tef_in_stage
// Input register. Captures one event transaction and forms the finger id.
// ----------------------------------------------------------------------------
module tef_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [4:0]          command,
    input  logic [9:0]          event_code,
    input  logic signed [31:0]  event_value,
    input  logic                down_free,
    output logic                step,
    output tef_pkg::event_t     evt
);

    logic            valid_reg;
    logic            valid_next;
    tef_pkg::event_t evt_reg;
    tef_pkg::event_t evt_next;
    logic            accept;
    logic [31:0]     value_u;

    assign in_ready = !valid_reg || down_free;
    assign accept   = in_valid && in_ready;
    assign step     = valid_reg && down_free;
    assign evt      = evt_reg;
    assign value_u  = $unsigned(event_value);

    always_comb
    begin
        evt_next.command   = command;
        evt_next.code      = event_code;
        evt_next.value     = value_u;
        evt_next.finger_id = value_u * tef_pkg::ID_SCALE + {22'b0, event_code};
        priority if (accept)
            valid_next = 1'b1;
        else if (down_free)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            evt_reg <= evt_next;
    end

endmodule

// File: rtl/tef_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tef_core
// Finger slot table and open sample state; one event is applied per step.
// ----------------------------------------------------------------------------
module tef_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tef_pkg::event_t   evt,
    output logic              emit,
    output tef_pkg::sample_t  sample
);

    logic [31:0]        slot_id_reg  [tef_pkg::NUM_SLOTS];
    logic [31:0]        slot_prs_reg [tef_pkg::NUM_SLOTS];
    logic               open_reg,    open_next;
    logic               has_slot_reg, has_slot_next;
    tef_pkg::slot_idx_t cur_slot_reg, cur_slot_next;
    logic [31:0]        x_reg,       x_next;
    logic [31:0]        y_reg,       y_next;
    logic [31:0]        prs_reg,     prs_next;
    logic               ignoring_reg, ignoring_next;

    logic [tef_pkg::NUM_SLOTS-1:0] hit_vec;
    logic [tef_pkg::NUM_SLOTS-1:0] free_vec;
    tef_pkg::slot_idx_t            hit_idx;
    tef_pkg::slot_idx_t            free_idx;
    logic                          hit_any;
    logic                          free_any;
    logic                          usable;
    logic                          closing;

    logic               id_we;
    tef_pkg::slot_idx_t id_idx;
    logic [31:0]        id_val;
    logic               prs_we;
    tef_pkg::slot_idx_t prs_idx;
    logic [31:0]        prs_val;

    // Lowest matching and lowest free slot.
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = tef_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            hit_vec[i]  = (slot_id_reg[i] == evt.finger_id);
            free_vec[i] = (slot_id_reg[i] == 32'd0);
            if (hit_vec[i])
                hit_idx = tef_pkg::SLOT_W'(i);
            if (free_vec[i])
                free_idx = tef_pkg::SLOT_W'(i);
        end
        hit_any  = |hit_vec;
        free_any = |free_vec;
    end

    assign usable  = open_reg && has_slot_reg && !ignoring_reg;
    assign closing = (evt.command == tef_pkg::CMD_FINGER) ||
                     (evt.command == tef_pkg::CMD_SYNC);
    assign emit    = step && closing && open_reg && has_slot_reg &&
                     (prs_reg != tef_pkg::UNSET_PRESSURE);

    assign sample.slot     = tef_pkg::slot_field(cur_slot_reg);
    assign sample.pos_x    = x_reg;
    assign sample.pos_y    = y_reg;
    assign sample.pressure = prs_reg;

    // prs_reg mirrors the current slot's table pressure while the sample is usable.
    always_comb
    begin
        open_next     = open_reg;
        has_slot_next = has_slot_reg;
        cur_slot_next = cur_slot_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        prs_next      = prs_reg;
        ignoring_next = ignoring_reg;
        id_we         = 1'b0;
        id_idx        = cur_slot_reg;
        id_val        = 32'd0;
        prs_we        = 1'b0;
        prs_idx       = cur_slot_reg;
        prs_val       = evt.value;
        unique case (evt.command)
            tef_pkg::CMD_KEY:
            begin
                if (usable && evt.code == tef_pkg::KEY_TOUCH)
                begin
                    if (!(prs_reg == tef_pkg::UNSET_PRESSURE && evt.value == 32'd0))
                    begin
                        prs_we   = 1'b1;
                        prs_next = evt.value;
                    end
                    if (evt.value == 32'd0)
                        id_we = 1'b1;
                end
            end
            tef_pkg::CMD_ABS:
            begin
                if (usable)
                begin
                    if (evt.code == tef_pkg::AXIS_X)
                        x_next = evt.value;
                    else if (evt.code == tef_pkg::AXIS_Y)
                        y_next = evt.value;
                end
            end
            tef_pkg::CMD_FINGER:
            begin
                open_next     = 1'b1;
                x_next        = 32'd0;
                y_next        = 32'd0;
                has_slot_next = hit_any || free_any;
                ignoring_next = !(hit_any || free_any);
                prs_next      = tef_pkg::UNSET_PRESSURE;
                if (hit_any)
                begin
                    cur_slot_next = hit_idx;
                    prs_next      = slot_prs_reg[hit_idx];
                end
                else if (free_any)
                begin
                    cur_slot_next = free_idx;
                    id_we         = 1'b1;
                    id_idx        = free_idx;
                    id_val        = evt.finger_id;
                    prs_we        = 1'b1;
                    prs_idx       = free_idx;
                    prs_val       = tef_pkg::UNSET_PRESSURE;
                end
            end
            tef_pkg::CMD_SYNC:
            begin
                open_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tef_pkg::NUM_SLOTS; i++)
            begin
                slot_id_reg[i]  <= 32'd0;
                slot_prs_reg[i] <= 32'd0;
            end
            open_reg     <= 1'b0;
            has_slot_reg <= 1'b0;
            cur_slot_reg <= '0;
            x_reg        <= 32'd0;
            y_reg        <= 32'd0;
            prs_reg      <= tef_pkg::UNSET_PRESSURE;
            ignoring_reg <= 1'b0;
        end
        else if (step)
        begin
            for (int i = 0; i < tef_pkg::NUM_SLOTS; i++)
            begin
                if (id_we && id_idx == tef_pkg::SLOT_W'(i))
                    slot_id_reg[i] <= id_val;
                if (prs_we && prs_idx == tef_pkg::SLOT_W'(i))
                    slot_prs_reg[i] <= prs_val;
            end
            open_reg     <= open_next;
            has_slot_reg <= has_slot_next;
            cur_slot_reg <= cur_slot_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            prs_reg      <= prs_next;
            ignoring_reg <= ignoring_next;
        end
    end

endmodule

// File: rtl/tef_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tef_out_stage
// Result register. Holds one finished sample until its transaction completes.
// ----------------------------------------------------------------------------
module tef_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  tef_pkg::sample_t   sample,
    output logic               free,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         slot,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [31:0]        touch_pressure
);

    logic             valid_reg;
    logic             valid_next;
    tef_pkg::sample_t data_reg;

    assign free           = !valid_reg || out_ready;
    assign out_valid      = valid_reg;
    assign slot           = data_reg.slot;
    assign pos_x          = $signed(data_reg.pos_x);
    assign pos_y          = $signed(data_reg.pos_y);
    assign touch_pressure = data_reg.pressure;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= sample;
    end

endmodule

// File: rtl/touch_event_finger_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_event_finger_tracker
// Assembles multitouch samples from a stream of touch events.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    command, event_code, event_value
//   out      source     out_valid/out_ready  slot, pos_x, pos_y, touch_pressure
//
// One event per cycle while in_ready is high. An event is held in the input
// register, then applied by slot lookup and state update; a closing event
// may load the sample into the result register. Reset clears the slot table
// and sample state at once. A held result stalls the event in the input
// register; in_ready drops only while both registers are full.
// ----------------------------------------------------------------------------
module touch_event_finger_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         command,
    input  logic [9:0]         event_code,
    input  logic signed [31:0] event_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         slot,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [31:0]        touch_pressure
);

    logic             down_free;
    logic             step;
    logic             emit;
    tef_pkg::event_t  evt;
    tef_pkg::sample_t sample;

    tef_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .event_code  (event_code),
        .event_value (event_value),
        .down_free   (down_free),
        .step        (step),
        .evt         (evt)
    );

    tef_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .evt    (evt),
        .emit   (emit),
        .sample (sample)
    );

    tef_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (emit),
        .sample         (sample),
        .free           (down_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot           (slot),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .touch_pressure (touch_pressure)
    );

endmodule

// File: rtl/tef_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tef_checker
// Port-level checks for the touch event finger tracker.
// ----------------------------------------------------------------------------
module tef_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         slot,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic [31:0]        touch_pressure
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(pos_x) &&
        $stable(pos_y) && $stable(touch_pressure))
        else $error("result changed while stalled");

    a_prs_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> touch_pressure != tef_pkg::UNSET_PRESSURE)
        else $error("sample emitted with unset pressure");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {29'b0, slot} < tef_pkg::NUM_SLOTS)
        else $error("slot out of range");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    a_in_ready_reset: assert property (@(posedge clk)
        !rst_n |-> in_ready && !out_valid)
        else $error("not idle in reset");

endmodule

bind touch_event_finger_tracker tef_checker u_tef_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .slot           (slot),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .touch_pressure (touch_pressure)
);
